>>> sv/smfp_pkg.sv
// shared types, constants and the hex digit decoder of the slcan motor feedback parser
// no dependencies
`timescale 1ns / 1ps

package smfp_pkg;

	localparam logic [7:0]  START_CHAR        = 8'h74;
	localparam logic [7:0]  HEX_LETTER_OFFSET = 8'd10;
	localparam logic [4:0]  POS_HUNT          = 5'd0;
	localparam logic [4:0]  POS_FIRST         = 5'd1;
	localparam logic [4:0]  ID_LAST_POS       = 5'd3;
	localparam logic [4:0]  DATA_FIRST_POS    = 5'd5;
	localparam logic [4:0]  DATA_LAST_POS     = 5'd18;
	localparam logic [4:0]  FRAME_LAST_POS    = 5'd20;

	localparam int unsigned ID_W    = 12;
	localparam int unsigned DATA_W  = 56;
	localparam int unsigned APB_W   = 32;
	localparam int unsigned PADDR_W = 3;

	localparam logic [ID_W-1:0] LEFT_ID_RESET  = 12'h201;
	localparam logic [ID_W-1:0] RIGHT_ID_RESET = 12'h202;

	// register index, taken from paddr bit 2
	localparam logic REG_LEFT_ID  = 1'b0;
	localparam logic REG_RIGHT_ID = 1'b1;

	typedef struct packed {
		logic        hit;
		logic        motor_index;
		logic [15:0] angle;
		logic [15:0] prev_angle;
		logic [15:0] speed;
		logic [15:0] current;
		logic [7:0]  temperature;
	} smfp_result_t;

	// non-hex characters decode as zero
	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		logic [7:0] val;
		val = 8'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			val = ch - 8'h30;
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			val = ch - 8'h41 + HEX_LETTER_OFFSET;
		end else if (ch >= 8'h61 && ch <= 8'h66) begin
			val = ch - 8'h61 + HEX_LETTER_OFFSET;
		end
		return val[3:0];
	endfunction

endpackage

>>> sv/smfp_ifs.sv
// valid/ready channel interfaces: received character stream and motor feedback results
// no dependencies
`timescale 1ns / 1ps

interface smfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface smfp_fb_if;
	logic        valid;
	logic        ready;
	logic        motor_index;
	logic [15:0] angle;
	logic [15:0] prev_angle;
	logic [15:0] speed;
	logic [15:0] current;
	logic [7:0]  temperature;

	modport source (output valid, output motor_index, output angle, output prev_angle,
		output speed, output current, output temperature, input ready);
	modport sink (input valid, input motor_index, input angle, input prev_angle,
		input speed, input current, input temperature, output ready);
endinterface

>>> sv/smfp_cfg_regs.sv
// apb-style register file holding the two motor identifiers
// depends on smfp_pkg
`timescale 1ns / 1ps

module smfp_cfg_regs
	import smfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready,
	output logic [ID_W-1:0]    left_id,
	output logic [ID_W-1:0]    right_id
);

	logic [ID_W-1:0] left_id_q;
	logic [ID_W-1:0] right_id_q;
	logic            wr_en;
	logic            reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_id_q  <= LEFT_ID_RESET;
			right_id_q <= RIGHT_ID_RESET;
		end else if (wr_en) begin
			case (reg_sel)
				REG_LEFT_ID: left_id_q <= pwdata[ID_W-1:0];
				REG_RIGHT_ID: right_id_q <= pwdata[ID_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LEFT_ID: prdata = {{(APB_W-ID_W){1'b0}}, left_id_q};
			REG_RIGHT_ID: prdata = {{(APB_W-ID_W){1'b0}}, right_id_q};
			default: prdata = '0;
		endcase
	end

	assign left_id  = left_id_q;
	assign right_id = right_id_q;

endmodule

>>> sv/smfp_parser_core.sv
// frame tracker: character position, id and data accumulators, per-motor angle store
// depends on smfp_pkg
`timescale 1ns / 1ps

module smfp_parser_core
	import smfp_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      ch,
	input  logic [ID_W-1:0] left_id,
	input  logic [ID_W-1:0] right_id,
	output smfp_result_t    result
);

	logic [4:0]        pos_q;
	logic [ID_W-1:0]   id_q;
	logic [DATA_W-1:0] data_q;
	logic [15:0]       angle_q [2];

	logic [3:0] nib;
	logic       last_char;
	logic       left_hit;
	logic       right_hit;
	logic       idx;

	assign nib       = hex_nibble(ch);
	assign last_char = (pos_q == FRAME_LAST_POS);
	assign left_hit  = (id_q == left_id);
	assign right_hit = (id_q == right_id);
	// left wins when both match
	assign idx       = !left_hit;

	always_comb begin
		result.hit         = last_char && (left_hit || right_hit);
		result.motor_index = idx;
		result.angle       = data_q[55:40];
		result.prev_angle  = angle_q[idx];
		result.speed       = data_q[39:24];
		result.current     = data_q[23:8];
		result.temperature = data_q[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_HUNT;
			id_q       <= '0;
			data_q     <= '0;
			angle_q[0] <= '0;
			angle_q[1] <= '0;
		end else if (step) begin
			if (pos_q == POS_HUNT) begin
				if (ch == START_CHAR) begin
					pos_q  <= POS_FIRST;
					id_q   <= '0;
					data_q <= '0;
				end
			end else begin
				if (pos_q <= ID_LAST_POS) begin
					id_q <= {id_q[ID_W-5:0], nib};
				end else if (pos_q >= DATA_FIRST_POS && pos_q <= DATA_LAST_POS) begin
					data_q <= {data_q[DATA_W-5:0], nib};
				end
				if (last_char) begin
					pos_q <= POS_HUNT;
					if (result.hit) begin
						angle_q[idx] <= data_q[55:40];
					end
				end else begin
					pos_q <= pos_q + 5'd1;
				end
			end
		end
	end

endmodule

>>> sv/slcan_motor_feedback_parser_unit.sv
// top level of the slcan motor feedback parser: input stage, frame tracker, result register
// depends on smfp_pkg, smfp_ifs, smfp_cfg_regs and smfp_parser_core
`timescale 1ns / 1ps

// usage
//   rx carries one received character per transfer (valid/ready); the block hunts for 't',
//   then takes 20 more characters: 3 id digits, one length digit (ignored), 14 data digits, 2 ignored
//   non-hex characters inside a frame count as digit zero; a 't' inside a frame does not restart
//   after the last character the id is matched against left_motor_id (index 0) and
//   right_motor_id (index 1), left wins on a tie; a match gives one transfer on fb with
//   angle, previous angle of that motor, speed, current and temperature, unmatched frames vanish
// configuration: apb-style port, left id at address 0, right id at address 4; the user must write
//   the ids only while the block is idle, the block does not enforce it; pready is tied high
// path: an accepted character is registered in the input stage, the result of the last frame
//   character is registered in the result register and shows on fb from there
// throughput: one character per cycle while no result is held off on fb; everything runs through the
//   input register, the tracker logic and the result register in a single pass
// stalls: when fb is held off with a result pending, the input stage freezes and rx.ready
//   drops once that stage is full; rx keeps taking one more character meanwhile
// reset (arst_n low): hunting for 't', accumulators and stored angles cleared, ids back to
//   0x201 and 0x202, no result pending

module slcan_motor_feedback_parser_unit
	import smfp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	smfp_byte_if.sink          rx,
	smfp_fb_if.source          fb,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]   pwdata,
	output logic [APB_W-1:0]   prdata,
	output logic               pready
);

	logic [ID_W-1:0] left_id;
	logic [ID_W-1:0] right_id;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic         fb_valid_q;
	smfp_result_t fb_q;

	logic         adv;
	logic         step;
	smfp_result_t result;

	smfp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.left_id  (left_id),
		.right_id (right_id)
	);

	// the input stage moves on whenever the result slot is free or drains this cycle
	assign adv      = !fb_valid_q || fb.ready;
	assign step     = valid_s1 && adv;
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	smfp_parser_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.ch       (byte_s1),
		.left_id  (left_id),
		.right_id (right_id),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_valid_q <= 1'b0;
		end else if (adv) begin
			fb_valid_q <= step && result.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && result.hit) begin
			fb_q <= result;
		end
	end

	assign fb.valid       = fb_valid_q;
	assign fb.motor_index = fb_q.motor_index;
	assign fb.angle       = fb_q.angle;
	assign fb.prev_angle  = fb_q.prev_angle;
	assign fb.speed       = fb_q.speed;
	assign fb.current     = fb_q.current;
	assign fb.temperature = fb_q.temperature;

	// an accepted character always lands in the input stage
	a_rx_lands: assert property (@(posedge clk) disable iff (!arst_n)
		rx.valid && rx.ready |=> valid_s1)
		else $error("accepted character missing from input stage");

	// a frozen input stage keeps its character
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost its character while stalled");

	// the tracker never advances over a pending, stalled result
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		!(fb_valid_q && !fb.ready && step))
		else $error("tracker stepped while result register blocked");

endmodule
